@@ hw/rtl/audio_cpu_io_and_timers_defines.svh @@
// Assertion macros for the audio I/O page checker.
// Standalone header; expects clk and rst_n in the scope of each use.
`ifndef AUDIO_CPU_IO_AND_TIMERS_DEFINES_SVH
`define AUDIO_CPU_IO_AND_TIMERS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACIO_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACIO_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/acio_pkg.sv @@
// Shared types and constants for the audio CPU I/O page and timers.
// No dependencies; used by the top level and its checker.
package acio_pkg;

  localparam int NUM_TIMERS = 3;
  localparam int DSP_DEPTH  = 128;
  localparam int DSP_AW     = 7;
  localparam int PRE_W      = 7;   // prescaler remainder, below 128

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_TICK      = 3'd2,
    OP_HOST_LOAD = 3'd3,
    OP_HOST_READ = 3'd4
  } op_t;

  // Low nibble of the I/O address
  localparam logic [3:0] REG_TEST     = 4'h0;
  localparam logic [3:0] REG_CONTROL  = 4'h1;
  localparam logic [3:0] REG_DSP_ADDR = 4'h2;
  localparam logic [3:0] REG_DSP_DATA = 4'h3;
  localparam logic [3:0] REG_PORT0    = 4'h4;
  localparam logic [3:0] REG_PORT1    = 4'h5;
  localparam logic [3:0] REG_PORT2    = 4'h6;
  localparam logic [3:0] REG_PORT3    = 4'h7;
  localparam logic [3:0] REG_SCRATCH0 = 4'h8;
  localparam logic [3:0] REG_SCRATCH1 = 4'h9;
  localparam logic [3:0] REG_T0_TGT   = 4'hA;
  localparam logic [3:0] REG_T1_TGT   = 4'hB;
  localparam logic [3:0] REG_T2_TGT   = 4'hC;
  localparam logic [3:0] REG_T0_OUT   = 4'hD;
  localparam logic [3:0] REG_T1_OUT   = 4'hE;
  localparam logic [3:0] REG_T2_OUT   = 4'hF;

  localparam logic [7:0] TEST_VALUE    = 8'h0A;
  localparam logic [7:0] CONTROL_FIXED = 8'h30;
  localparam logic [3:0] TIMER_OUT_RST = 4'hF;

  // Control register bit positions
  localparam int CTL_ROM_BIT  = 7;
  localparam int CTL_CLR23BIT = 5;
  localparam int CTL_CLR01BIT = 4;

  // Prescaler period: timers 0 and 1 divide by 128, timer 2 by 16
  function automatic logic [7:0] timer_period(input logic [1:0] idx);
    logic [7:0] p;
    case (idx)
      2'd2:    p = 8'd16;
      default: p = 8'd128;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/acio_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];   // old data on a same-address write
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/audio_cpu_io_and_timers.sv @@
// I/O register page and three timers of an audio CPU.
// Depends on acio_pkg and acio_ram.
//
// Usage:
//   Input channel (in_*): one transfer per bus access, tick or host access.
//   in_operation selects CPU read, CPU write, tick (in_cycles elapsed),
//   host port load or host port read; in_register_req is the low nibble
//   of the 0xF0-0xFF address, in_port_index the host-side port.
//   Result channel (out_*): exactly one transfer per input transfer, in
//   order. out_read_data carries the read value (zero for non-reads),
//   out_rom_visible the boot ROM visibility after the item.
//   Latency: result is valid the cycle after the input transfer.
//   Throughput: one item per cycle. All state updates are done in a single
//   combinational pass from the state registers into the result register;
//   a tick moves each timer by at most one count, so no iteration is needed.
//   The DSP register file sits in a 128 x 8 RAM whose registered read port
//   always points at the next DSP address, so 0xF3 reads see it in time.
//   Stall: in_ready is high while the result register is empty or being
//   taken; if the receiver holds out_ready low, the result holds and the
//   input side stalls at once, since the single result register is full.
//   Reset (rst_n low, synchronous): timers, ports, control and the DSP
//   file valid bits are cleared (timer outputs go to 15, ROM visible);
//   the DSP file reads as zero until each entry is written. No clearing
//   pass is needed, so the block accepts items right after reset.
module audio_cpu_io_and_timers (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [3:0] in_register_req,
  input  logic [7:0] in_data,
  input  logic [3:0] in_cycles,
  input  logic [1:0] in_port_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_rom_visible
);

  localparam int NT = acio_pkg::NUM_TIMERS;
  localparam int AW = acio_pkg::DSP_AW;
  localparam int PW = acio_pkg::PRE_W;

  // ---------------- state ----------------
  logic [PW-1:0] pre_r   [NT];
  logic [PW-1:0] pre_nxt [NT];
  logic [7:0]    cnt_r   [NT];
  logic [7:0]    cnt_nxt [NT];
  logic [7:0]    tgt_r   [NT];
  logic [7:0]    tgt_nxt [NT];
  logic [3:0]    tout_r  [NT];
  logic [3:0]    tout_nxt[NT];
  logic [NT-1:0] en_r, en_nxt;
  logic          rom_r, rom_nxt;
  logic [7:0]    dsp_addr_r, dsp_addr_nxt;
  logic [7:0]    inp_r   [4];
  logic [7:0]    inp_nxt [4];
  logic [7:0]    outp_r  [4];
  logic [7:0]    outp_nxt[4];
  logic [7:0]    scr_r   [2];
  logic [7:0]    scr_nxt [2];

  // DSP file: RAM plus one valid bit per entry
  logic [acio_pkg::DSP_DEPTH-1:0] dvld_r;
  logic          dsp_we;
  logic [7:0]    ram_q;
  logic          dvld_rd_r;     // valid bit of the entry now in ram_q
  logic          fwd_hit_r;     // last write landed on the entry now addressed
  logic [7:0]    fwd_data_r;
  logic [7:0]    dsp_cur;       // dsp_file[dsp_addr_r]
  logic          fwd_hit_nxt;

  // ---------------- result register ----------------
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic          rom_out_r;
  logic          accept;

  // timer scratch
  logic [7:0]    psum   [NT];
  logic [7:0]    prd    [NT];
  logic [7:0]    pleft  [NT];
  logic [7:0]    cinc   [NT];
  logic          pwrap  [NT];

  acio_pkg::op_t op;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign op       = acio_pkg::op_t'(in_operation);

  assign dsp_cur = fwd_hit_r ? fwd_data_r : (dvld_rd_r ? ram_q : 8'd0);

  // ---------------- next state and read data ----------------
  always_comb begin
    for (int t = 0; t < NT; t++) begin
      pre_nxt[t]  = pre_r[t];
      cnt_nxt[t]  = cnt_r[t];
      tgt_nxt[t]  = tgt_r[t];
      tout_nxt[t] = tout_r[t];
      // tick arithmetic: prescaler stays below its period, so at most one wrap
      prd[t]   = acio_pkg::timer_period(2'(t));
      psum[t]  = 8'({1'b0, pre_r[t]}) + 8'(in_cycles);
      pwrap[t] = psum[t] >= prd[t];
      pleft[t] = pwrap[t] ? (psum[t] - prd[t]) : psum[t];
      cinc[t]  = cnt_r[t] + 8'd1;
    end
    for (int i = 0; i < 4; i++) begin
      inp_nxt[i]  = inp_r[i];
      outp_nxt[i] = outp_r[i];
    end
    scr_nxt[0]   = scr_r[0];
    scr_nxt[1]   = scr_r[1];
    en_nxt       = en_r;
    rom_nxt      = rom_r;
    dsp_addr_nxt = dsp_addr_r;
    dsp_we       = 1'b0;
    rd_nxt       = 8'd0;

    if (accept) begin
      case (op)
        acio_pkg::OP_READ: begin
          case (in_register_req)
            acio_pkg::REG_TEST:     rd_nxt = acio_pkg::TEST_VALUE;
            acio_pkg::REG_CONTROL:  rd_nxt = {rom_r, 4'b0000, en_r} | acio_pkg::CONTROL_FIXED;
            acio_pkg::REG_DSP_ADDR: rd_nxt = dsp_addr_r;
            acio_pkg::REG_DSP_DATA: rd_nxt = dsp_cur;
            acio_pkg::REG_PORT0,
            acio_pkg::REG_PORT1,
            acio_pkg::REG_PORT2,
            acio_pkg::REG_PORT3:    rd_nxt = inp_r[in_register_req[1:0]];
            acio_pkg::REG_SCRATCH0: rd_nxt = scr_r[0];
            acio_pkg::REG_SCRATCH1: rd_nxt = scr_r[1];
            acio_pkg::REG_T0_OUT: begin
              rd_nxt      = {4'd0, tout_r[0]};
              tout_nxt[0] = 4'd0;
            end
            acio_pkg::REG_T1_OUT: begin
              rd_nxt      = {4'd0, tout_r[1]};
              tout_nxt[1] = 4'd0;
            end
            acio_pkg::REG_T2_OUT: begin
              rd_nxt      = {4'd0, tout_r[2]};
              tout_nxt[2] = 4'd0;
            end
            default: rd_nxt = 8'd0;   // target registers are write-only
          endcase
        end
        acio_pkg::OP_WRITE: begin
          case (in_register_req)
            acio_pkg::REG_CONTROL: begin
              rom_nxt = in_data[acio_pkg::CTL_ROM_BIT];
              if (in_data[acio_pkg::CTL_CLR23BIT]) begin
                inp_nxt[2] = 8'd0;
                inp_nxt[3] = 8'd0;
              end
              if (in_data[acio_pkg::CTL_CLR01BIT]) begin
                inp_nxt[0] = 8'd0;
                inp_nxt[1] = 8'd0;
              end
              en_nxt = in_data[NT-1:0];
            end
            acio_pkg::REG_DSP_ADDR: dsp_addr_nxt = in_data;
            acio_pkg::REG_DSP_DATA: dsp_we = 1'b1;
            acio_pkg::REG_PORT0,
            acio_pkg::REG_PORT1,
            acio_pkg::REG_PORT2,
            acio_pkg::REG_PORT3:    outp_nxt[in_register_req[1:0]] = in_data;
            acio_pkg::REG_SCRATCH0: scr_nxt[0] = in_data;
            acio_pkg::REG_SCRATCH1: scr_nxt[1] = in_data;
            acio_pkg::REG_T0_TGT:   tgt_nxt[0] = in_data;
            acio_pkg::REG_T1_TGT:   tgt_nxt[1] = in_data;
            acio_pkg::REG_T2_TGT:   tgt_nxt[2] = in_data;
            default: ;               // test and timer outputs ignore writes
          endcase
        end
        acio_pkg::OP_TICK: begin
          for (int t = 0; t < NT; t++) begin
            // disabled timer keeps only the remainder, which is the same value
            pre_nxt[t] = pleft[t][PW-1:0];
            if (pwrap[t] && en_r[t]) begin
              if (cinc[t] == tgt_r[t]) begin
                cnt_nxt[t]  = 8'd0;
                tout_nxt[t] = tout_r[t] + 4'd1;
              end else begin
                cnt_nxt[t]  = cinc[t];
              end
            end
          end
        end
        acio_pkg::OP_HOST_LOAD: inp_nxt[in_port_index] = in_data;
        acio_pkg::OP_HOST_READ: rd_nxt = outp_r[in_port_index];
        default: ;
      endcase
    end
  end

  assign fwd_hit_nxt   = dsp_we && (dsp_addr_r[AW-1:0] == dsp_addr_nxt[AW-1:0]);
  assign out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // ---------------- DSP register file ----------------
  acio_ram #(
    .WIDTH(8),
    .DEPTH(acio_pkg::DSP_DEPTH)
  ) u_dsp_ram (
    .clk  (clk),
    .we   (dsp_we),
    .waddr(dsp_addr_r[AW-1:0]),
    .wdata(in_data),
    .raddr(dsp_addr_nxt[AW-1:0]),   // read ahead for the next cycle
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r    <= '0;
      dvld_rd_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (dsp_we) begin
        dvld_r[dsp_addr_r[AW-1:0]] <= 1'b1;
      end
      dvld_rd_r <= dvld_r[dsp_addr_nxt[AW-1:0]];
      fwd_hit_r <= fwd_hit_nxt;
    end
    fwd_data_r <= in_data;
  end

  // ---------------- register state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NT; t++) begin
        pre_r[t]  <= '0;
        cnt_r[t]  <= 8'd0;
        tgt_r[t]  <= 8'd0;
        tout_r[t] <= acio_pkg::TIMER_OUT_RST;
      end
      for (int i = 0; i < 4; i++) begin
        inp_r[i]  <= 8'd0;
        outp_r[i] <= 8'd0;
      end
      scr_r[0]    <= 8'd0;
      scr_r[1]    <= 8'd0;
      en_r        <= '0;
      rom_r       <= 1'b1;
      dsp_addr_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      for (int t = 0; t < NT; t++) begin
        pre_r[t]  <= pre_nxt[t];
        cnt_r[t]  <= cnt_nxt[t];
        tgt_r[t]  <= tgt_nxt[t];
        tout_r[t] <= tout_nxt[t];
      end
      for (int i = 0; i < 4; i++) begin
        inp_r[i]  <= inp_nxt[i];
        outp_r[i] <= outp_nxt[i];
      end
      scr_r[0]    <= scr_nxt[0];
      scr_r[1]    <= scr_nxt[1];
      en_r        <= en_nxt;
      rom_r       <= rom_nxt;
      dsp_addr_r  <= dsp_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r      <= rd_nxt;
      rom_out_r <= rom_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = rd_r;
  assign out_rom_visible = rom_out_r;

endmodule

@@ hw/rtl/acio_chk.sv @@
// Port-level checker for the audio CPU I/O page, bound to the top level.
// Depends on acio_pkg and audio_cpu_io_and_timers_defines.svh.
`include "audio_cpu_io_and_timers_defines.svh"

module acio_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_operation,
  input logic [3:0] in_register_req,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_rom_visible
);

  logic       in_xfer;
  logic       is_rd;
  logic       ctl_rd;
  logic       test_rd;
  logic       nonrd_xfer;
  logic       out_stall;
  logic [8:0] out_payload;
  logic       test_ok;
  logic       ctl_ok;

  assign in_xfer = in_valid && in_ready;
  assign is_rd   = (in_operation == acio_pkg::OP_READ) ||
                   (in_operation == acio_pkg::OP_HOST_READ);
  assign ctl_rd  = in_xfer && (in_operation == acio_pkg::OP_READ) &&
                   (in_register_req == acio_pkg::REG_CONTROL);
  assign test_rd = in_xfer && (in_operation == acio_pkg::OP_READ) &&
                   (in_register_req == acio_pkg::REG_TEST);
  assign nonrd_xfer  = in_xfer && !is_rd;
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_read_data, out_rom_visible};
  assign test_ok     = (out_read_data == acio_pkg::TEST_VALUE);
  assign ctl_ok      = (out_read_data[7] == out_rom_visible) &&
                       (out_read_data[6:3] == 4'b0110);

  // stalled result holds
  `ACIO_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "stalled result changed")
  // every accepted item shows its result in the following cycle
  `ACIO_NEXT(a_latency, in_xfer, out_valid, "no result after input transfer")
  // items that do not read return zero
  `ACIO_NEXT(a_nonread_zero, nonrd_xfer, out_read_data == 8'd0, "non-read returned data")
  // test register value
  `ACIO_NEXT(a_test_reg, test_rd, test_ok, "test register mismatch")
  // control read agrees with the ROM visibility output
  `ACIO_NEXT(a_ctl_rom, ctl_rd, ctl_ok, "control read mismatch")

endmodule

bind audio_cpu_io_and_timers acio_chk u_acio_chk (.*);
